// ----- rtl/mgsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mgsr_pkg;

   localparam int COL_W       = 6;
   localparam int ROW_END_W   = 15;
   localparam int MAX_RESULTS = 64;
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
   localparam int EROW_W      = 6;
   localparam int ECOL_W      = 3;
   localparam int PTS_W       = 4;
   localparam int XCNT_W      = 4;
   localparam int YCNT_W      = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_POINTS = 2'd0,
      CSR_Y_POINTS = 2'd1,
      CSR_X_COUNT  = 2'd2,
      CSR_Y_COUNT  = 2'd3
   } csr_idx_type;

   localparam logic KIND_MASK = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   typedef struct packed {
      logic [PTS_W-1:0]  x_points;
      logic [PTS_W-1:0]  y_points;
      logic [XCNT_W-1:0] x_count;
      logic [YCNT_W-1:0] y_count;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0]     column;
      logic                 has_column;
      logic [ROW_END_W-1:0] row_end;
      logic                 last;
      logic                 finished;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/mgsr_mask_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mgsr_mask_mem #(
   parameter int MAX_X_ELEMENTS = 8,
   parameter int MAX_Y_ELEMENTS = 64,
   localparam int AW = (MAX_Y_ELEMENTS > 1) ? $clog2(MAX_Y_ELEMENTS) : 1,
   localparam int XW = (MAX_X_ELEMENTS > 1) ? $clog2(MAX_X_ELEMENTS) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_row,
   input  wire logic [XW-1:0]             wr_col,
   input  wire logic                      wr_bit,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr_cur,
   input  wire logic [AW-1:0]             rd_addr_prev,
   output logic      [MAX_X_ELEMENTS-1:0] rd_row_cur,
   output logic      [MAX_X_ELEMENTS-1:0] rd_row_prev
);

   logic [MAX_X_ELEMENTS-1:0] mem [MAX_Y_ELEMENTS];
   logic [MAX_Y_ELEMENTS-1:0] vld_ff;
   logic [MAX_X_ELEMENTS-1:0] fresh_row;
   logic [MAX_X_ELEMENTS-1:0] row_cur_ff;
   logic [MAX_X_ELEMENTS-1:0] row_prev_ff;

   // a row never written reads as zero, so its first write clears the other bits
   always_comb begin
      fresh_row         = '0;
      fresh_row[wr_col] = wr_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_row] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (vld_ff[wr_row]) begin
            mem[wr_row][wr_col] <= wr_bit;
         end else begin
            mem[wr_row] <= fresh_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         row_cur_ff  <= vld_ff[rd_addr_cur] ? mem[rd_addr_cur] : '0;
         row_prev_ff <= vld_ff[rd_addr_prev] ? mem[rd_addr_prev] : '0;
      end
   end

   assign rd_row_cur  = row_cur_ff;
   assign rd_row_prev = row_prev_ff;

endmodule

`default_nettype wire

// ----- rtl/mgsr_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mgsr_walk #(
   parameter int MAX_X_ELEMENTS = 8,
   parameter int MAX_Y_ELEMENTS = 64,
   parameter int MAX_POINTS     = 9,
   localparam int AW = (MAX_Y_ELEMENTS > 1) ? $clog2(MAX_Y_ELEMENTS) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mgsr_pkg::cfg_type         cfg,
   input  wire logic                      restart,
   input  wire logic                      start,
   output logic                           ready,
   output logic                           rd_en,
   output logic      [AW-1:0]             rd_addr_cur,
   output logic      [AW-1:0]             rd_addr_prev,
   input  wire logic [MAX_X_ELEMENTS-1:0] row_cur,
   input  wire logic [MAX_X_ELEMENTS-1:0] row_prev,
   output mgsr_pkg::rsp_type              rsp,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready
);

   import mgsr_pkg::*;

   localparam int XW   = (MAX_X_ELEMENTS > 1) ? $clog2(MAX_X_ELEMENTS) : 1;
   localparam int XNW  = $clog2(MAX_X_ELEMENTS + 1);
   localparam int ERW  = $clog2(MAX_Y_ELEMENTS + 1);
   localparam int PW   = $clog2(MAX_POINTS + 1);
   localparam int KW   = $clog2(MAX_POINTS);
   localparam int SUMW = $clog2(MAX_X_ELEMENTS * (MAX_POINTS - 1) + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_COUNT = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [ERW-1:0]       elem_row_ff, elem_row_in;
   logic [KW-1:0]        point_row_ff, point_row_in;
   logic [ROW_END_W-1:0] kept_ff, kept_in;
   logic                 all_done_ff, all_done_in;
   logic                 row_first_ff, row_first_in;
   logic [XW-1:0]        j_ff, j_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 k_first_ff, k_first_in;
   logic [SUMW-1:0]      sum_ff, sum_in;
   logic [NUM_W-1:0]     n_ff, n_in;
   logic [NUM_W-1:0]     emitted_ff, emitted_in;
   logic [COL_W-1:0]     base_ff, base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [PW-1:0]        xq, yq;
   logic [XNW-1:0]       xn;
   logic [ERW-1:0]       yn;
   logic                 skip;
   logic [ERW-1:0]       er_n;
   logic [KW-1:0]        pr_n;
   logic                 done_n;
   logic                 prev_ok;
   logic                 cur_bit, xp, yp, pl, keep, strt;
   logic [PW-1:0]        cnt_j;
   logic [SUMW-1:0]      total;
   logic                 j_last;
   logic [KW-1:0]        kk;
   logic                 in_range;
   logic                 k_end;
   logic                 slot_free;

   // clamp the configuration at use
   always_comb begin
      if (16'(cfg.x_points) < 16'd2) begin
         xq = PW'(2);
      end else if (16'(cfg.x_points) > 16'(MAX_POINTS)) begin
         xq = PW'(MAX_POINTS);
      end else begin
         xq = PW'(cfg.x_points);
      end
      if (16'(cfg.y_points) < 16'd2) begin
         yq = PW'(2);
      end else if (16'(cfg.y_points) > 16'(MAX_POINTS)) begin
         yq = PW'(MAX_POINTS);
      end else begin
         yq = PW'(cfg.y_points);
      end
      if (16'(cfg.x_count) < 16'd1) begin
         xn = XNW'(1);
      end else if (16'(cfg.x_count) > 16'(MAX_X_ELEMENTS)) begin
         xn = XNW'(MAX_X_ELEMENTS);
      end else begin
         xn = XNW'(cfg.x_count);
      end
      if (16'(cfg.y_count) < 16'd1) begin
         yn = ERW'(1);
      end else if (16'(cfg.y_count) > 16'(MAX_Y_ELEMENTS)) begin
         yn = ERW'(MAX_Y_ELEMENTS);
      end else begin
         yn = ERW'(cfg.y_count);
      end
   end

   // advance past an exhausted element row
   always_comb begin
      skip   = 16'(point_row_ff) + 16'd1 >= 16'(yq);
      er_n   = skip ? elem_row_ff + ERW'(1) : elem_row_ff;
      pr_n   = skip ? '0 : point_row_ff;
      done_n = all_done_ff || (16'(er_n) >= 16'(yn));
   end

   assign ready        = (state_ff == ST_IDLE);
   assign rd_en        = start && (state_ff == ST_IDLE) && !done_n;
   assign rd_addr_cur  = AW'(er_n);
   assign rd_addr_prev = AW'(er_n - ERW'(1));

   // neighbor bits of element column j
   always_comb begin
      prev_ok = (elem_row_ff != '0);
      cur_bit = row_cur[j_ff];
      xp      = (j_ff != '0) ? row_cur[j_ff - XW'(1)] : 1'b0;
      yp      = prev_ok && row_prev[j_ff];
      pl      = prev_ok && (j_ff != '0) && row_prev[j_ff - XW'(1)];
      if (row_first_ff) begin
         keep = cur_bit && yp;
         strt = !(xp && yp && pl);
      end else begin
         keep = cur_bit;
         strt = !xp;
      end
      cnt_j    = keep ? (xq - PW'(1) - PW'(strt)) : '0;
      total    = sum_ff + SUMW'(cnt_j);
      j_last   = (16'(j_ff) + 16'd1 == 16'(xn));
      kk       = k_first_ff ? KW'(strt) : k_ff;
      in_range = keep && (16'(kk) + 16'd2 <= 16'(xq));
      k_end    = (16'(kk) + 16'd2 == 16'(xq));
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      elem_row_in  = elem_row_ff;
      point_row_in = point_row_ff;
      kept_in      = kept_ff;
      all_done_in  = all_done_ff;
      row_first_in = row_first_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      k_first_in   = k_first_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      emitted_in   = emitted_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (restart) begin
               elem_row_in  = '0;
               point_row_in = KW'(1);
               kept_in      = '0;
               all_done_in  = 1'b0;
            end else if (start) begin
               if (!all_done_ff) begin
                  elem_row_in  = er_n;
                  point_row_in = pr_n;
                  all_done_in  = done_n;
               end
               row_first_in = (pr_n == '0);
               j_in         = '0;
               sum_in       = '0;
               state_in     = done_n ? ST_FIN : ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (j_last) begin
               if (16'(total) > 16'(MAX_RESULTS)) begin
                  n_in = NUM_W'(MAX_RESULTS);
               end else begin
                  n_in = NUM_W'(total);
               end
               kept_in      = kept_ff + ROW_END_W'(n_in);
               point_row_in = point_row_ff + KW'(1);
               j_in         = '0;
               k_first_in   = 1'b1;
               emitted_in   = '0;
               base_in      = '0;
               state_in     = ST_EMIT;
            end else begin
               sum_in = total;
               j_in   = j_ff + XW'(1);
            end
         end
         ST_EMIT: begin
            if (n_ff == '0) begin
               if (slot_free) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.column     = '0;
                  rsp_in.has_column = 1'b0;
                  rsp_in.row_end    = kept_ff;
                  rsp_in.last       = 1'b1;
                  rsp_in.finished   = 1'b0;
                  state_in          = ST_IDLE;
               end
            end else if (in_range) begin
               if (slot_free) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.column     = base_ff + COL_W'(kk) - COL_W'(1);
                  rsp_in.has_column = 1'b1;
                  rsp_in.row_end    = kept_ff;
                  rsp_in.last       = (emitted_ff + NUM_W'(1) == n_ff);
                  rsp_in.finished   = 1'b0;
                  emitted_in        = emitted_ff + NUM_W'(1);
                  if (emitted_ff + NUM_W'(1) == n_ff) begin
                     state_in = ST_IDLE;
                  end else if (k_end) begin
                     j_in       = j_ff + XW'(1);
                     base_in    = base_ff + COL_W'(xq - PW'(1));
                     k_first_in = 1'b1;
                  end else begin
                     k_in       = kk + KW'(1);
                     k_first_in = 1'b0;
                  end
               end
            end else begin
               j_in       = j_ff + XW'(1);
               base_in    = base_ff + COL_W'(xq - PW'(1));
               k_first_in = 1'b1;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.column     = '0;
               rsp_in.has_column = 1'b0;
               rsp_in.row_end    = kept_ff;
               rsp_in.last       = 1'b1;
               rsp_in.finished   = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elem_row_ff  <= '0;
         point_row_ff <= KW'(1);
         kept_ff      <= '0;
         all_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elem_row_ff  <= elem_row_in;
         point_row_ff <= point_row_in;
         kept_ff      <= kept_in;
         all_done_ff  <= all_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_first_ff <= row_first_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      k_first_ff   <= k_first_in;
      sum_ff       <= sum_in;
      n_ff         <= n_in;
      emitted_ff   <= emitted_in;
      base_ff      <= base_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/masked_grid_sparse_row_index.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sparse-row index generator over a masked 2-D element grid. Mask items (tuser 0) set one
// element bit and restart the walk; row items (tuser 1) return the kept column indices of the
// next quadrature-point row, one item each, all carrying the row-end count, tlast on the final
// one. A row item with nothing kept gives one item with has_column 0; once every row is done a
// row item gives one item with finished set. A row item is accepted and reads the current and
// upper mask rows from the row memory, then counts the kept functions over x_count element
// columns, then emits the indices one at a time, stepping past element columns with nothing to
// emit and holding while the output is not taken. One item is in work at a time. Mask rows
// carry valid flags cleared by reset, so no clearing pass is needed. Any csr write restarts the
// walk and keeps the mask; csr writes only while the block is idle.

module masked_grid_sparse_row_index #(
   parameter int MAX_X_ELEMENTS = 8,
   parameter int MAX_Y_ELEMENTS = 64,
   parameter int MAX_POINTS     = 9
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [15:0]                          req_tdata,  // elem_row, elem_col, used
   input  wire logic                                 req_tuser,  // kind
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [23:0]                          rsp_tdata,  // column, has_column, row_end
   output logic                                      rsp_tlast,
   output logic                                      rsp_tuser,  // finished
   input  wire logic                                 csr_we,
   input  wire logic [mgsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mgsr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import mgsr_pkg::*;

   localparam int AW = (MAX_Y_ELEMENTS > 1) ? $clog2(MAX_Y_ELEMENTS) : 1;
   localparam int XW = (MAX_X_ELEMENTS > 1) ? $clog2(MAX_X_ELEMENTS) : 1;

   logic [PTS_W-1:0]          x_points_ff, x_points_in;
   logic [PTS_W-1:0]          y_points_ff, y_points_in;
   logic [XCNT_W-1:0]         x_count_ff, x_count_in;
   logic [YCNT_W-1:0]         y_count_ff, y_count_in;
   cfg_type                   cfg;

   logic [EROW_W-1:0]         elem_row;
   logic [ECOL_W-1:0]         elem_col;
   logic                      used;
   logic                      req_accept;
   logic                      mask_wr;
   logic                      row_req;
   logic                      restart;
   logic                      in_store;

   logic                      rd_en;
   logic [AW-1:0]             rd_addr_cur;
   logic [AW-1:0]             rd_addr_prev;
   logic [MAX_X_ELEMENTS-1:0] row_cur;
   logic [MAX_X_ELEMENTS-1:0] row_prev;
   rsp_type                   rsp;

   assign elem_row   = req_tdata[EROW_W-1:0];
   assign elem_col   = req_tdata[EROW_W+ECOL_W-1:EROW_W];
   assign used       = req_tdata[EROW_W+ECOL_W];
   assign req_accept = req_tvalid && req_tready;
   assign in_store   = (16'(elem_row) < 16'(MAX_Y_ELEMENTS))
                    && (16'(elem_col) < 16'(MAX_X_ELEMENTS));
   assign mask_wr    = req_accept && (req_tuser == KIND_MASK);
   assign row_req    = req_tvalid && (req_tuser == KIND_ROW);
   assign restart    = mask_wr || csr_we;

   always_comb begin
      x_points_in = x_points_ff;
      y_points_in = y_points_ff;
      x_count_in  = x_count_ff;
      y_count_in  = y_count_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_X_POINTS: x_points_in = csr_wdata[PTS_W-1:0];
            CSR_Y_POINTS: y_points_in = csr_wdata[PTS_W-1:0];
            CSR_X_COUNT:  x_count_in  = csr_wdata[XCNT_W-1:0];
            CSR_Y_COUNT:  y_count_in  = csr_wdata[YCNT_W-1:0];
            default:      x_points_in = x_points_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_points_ff <= PTS_W'(9);
         y_points_ff <= PTS_W'(9);
         x_count_ff  <= XCNT_W'(8);
         y_count_ff  <= YCNT_W'(64);
      end else begin
         x_points_ff <= x_points_in;
         y_points_ff <= y_points_in;
         x_count_ff  <= x_count_in;
         y_count_ff  <= y_count_in;
      end
   end

   assign cfg = {x_points_ff, y_points_ff, x_count_ff, y_count_ff};

   mgsr_mask_mem #(
      .MAX_X_ELEMENTS (MAX_X_ELEMENTS),
      .MAX_Y_ELEMENTS (MAX_Y_ELEMENTS)
   ) u_mem (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (mask_wr && in_store),
      .wr_row       (AW'(elem_row)),
      .wr_col       (XW'(elem_col)),
      .wr_bit       (used),
      .rd_en        (rd_en),
      .rd_addr_cur  (rd_addr_cur),
      .rd_addr_prev (rd_addr_prev),
      .rd_row_cur   (row_cur),
      .rd_row_prev  (row_prev)
   );

   mgsr_walk #(
      .MAX_X_ELEMENTS (MAX_X_ELEMENTS),
      .MAX_Y_ELEMENTS (MAX_Y_ELEMENTS),
      .MAX_POINTS     (MAX_POINTS)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .restart      (restart),
      .start        (row_req),
      .ready        (req_tready),
      .rd_en        (rd_en),
      .rd_addr_cur  (rd_addr_cur),
      .rd_addr_prev (rd_addr_prev),
      .row_cur      (row_cur),
      .row_prev     (row_prev),
      .rsp          (rsp),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready)
   );

   assign rsp_tdata = {2'b00, rsp.row_end, rsp.has_column, rsp.column};
   assign rsp_tlast = rsp.last;
   assign rsp_tuser = rsp.finished;

endmodule

`default_nettype wire

// ----- test/tb_masked_grid_sparse_row_index.sv -----
`timescale 1ns / 1ps

module tb_masked_grid_sparse_row_index;
   import mgsr_pkg::*;

   localparam int GRID_COLS      = 8;
   localparam int GRID_ROWS      = 64;
   localparam int GRID_POINTS    = 9;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int END_CYCLES     = 200;
   localparam int PHASE_ITEMS    = 40;
   localparam int NUM_PHASES     = 8;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_op_type;

   typedef struct {
      step_op_type            op;
      logic                   kind;
      logic [EROW_W-1:0]      erow;
      logic [ECOL_W-1:0]      ecol;
      logic                   used;
      csr_idx_type            reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      bit                     typed;
      rsp_type                want;
   } dir_step_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // elem_row, elem_col, used
   logic                  req_tuser;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;   // column, has_column, row_end
   logic                  rsp_tlast;
   logic                  rsp_tuser;   // finished
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // grid model
   logic [GRID_COLS-1:0]  mask_rows [GRID_ROWS];
   logic [PTS_W-1:0]      cfg_xp;
   logic [PTS_W-1:0]      cfg_yp;
   logic [XCNT_W-1:0]     cfg_xc;
   logic [YCNT_W-1:0]     cfg_yc;
   int unsigned           walk_erow;
   int unsigned           walk_prow;
   logic [ROW_END_W-1:0]  kept_total;
   bit                    walk_done;

   rsp_type               row_rsp_q [$];
   rsp_type               head_rsp;
   dir_step_type          dir_steps [$];
   int                    mismatch_count = 0;
   int                    result_count = 0;
   int                    stall_cycles = 0;
   int                    src_idle_pct = 0;
   int                    rsp_stall_pct = 0;

   masked_grid_sparse_row_index u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic rsp_type make_rsp(int unsigned column, bit has, int unsigned row_end,
                                        bit last, bit fin);
      rsp_type r;
      r.column     = column[COL_W-1:0];
      r.has_column = has;
      r.row_end    = row_end[ROW_END_W-1:0];
      r.last       = last;
      r.finished   = fin;
      return r;
   endfunction

   function automatic void restart_walk();
      walk_erow  = 0;
      walk_prow  = 1;
      kept_total = '0;
      walk_done  = 1'b0;
   endfunction

   function automatic void write_grid_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_X_POINTS: cfg_xp = val[PTS_W-1:0];
         CSR_Y_POINTS: cfg_yp = val[PTS_W-1:0];
         CSR_X_COUNT:  cfg_xc = val[XCNT_W-1:0];
         CSR_Y_COUNT:  cfg_yc = val[YCNT_W-1:0];
         default: ;
      endcase
      restart_walk();
   endfunction

   function automatic void store_mask_bit(int unsigned erow, int unsigned ecol, logic used);
      mask_rows[erow][ecol] = used;
      restart_walk();
   endfunction

   // emit the kept columns of the next point row
   function automatic void walk_next_row(output rsp_type res [$]);
      int unsigned xq;
      int unsigned yq;
      int unsigned xn;
      int unsigned yn;
      int unsigned start;
      int unsigned i;
      int unsigned cols [$];
      logic        xp;
      logic        yp;
      logic        xpyp;
      xq = clamp_to(cfg_xp, 2, GRID_POINTS);
      yq = clamp_to(cfg_yp, 2, GRID_POINTS);
      xn = clamp_to(cfg_xc, 1, GRID_COLS);
      yn = clamp_to(cfg_yc, 1, GRID_ROWS);
      while (!walk_done && walk_prow >= yq - 1) begin
         walk_erow++;
         walk_prow = 0;
         if (walk_erow >= yn) walk_done = 1'b1;
      end
      if (!walk_done && walk_erow >= yn) walk_done = 1'b1;
      if (walk_done) begin
         res.push_back(make_rsp(0, 1'b0, kept_total, 1'b1, 1'b1));
         return;
      end
      i = walk_erow;
      for (int j = 0; j < xn; j++) begin
         if (!mask_rows[i][j]) continue;
         xp   = (j > 0) ? mask_rows[i][j-1] : 1'b0;
         yp   = (i > 0) ? mask_rows[i-1][j] : 1'b0;
         xpyp = (xp && yp) ? mask_rows[i-1][j-1] : 1'b0;
         if (walk_prow == 0) begin
            if (!yp) continue;
            start = xpyp ? 0 : 1;
         end else begin
            start = xp ? 0 : 1;
         end
         for (int unsigned k = start; k + 1 < xq; k++) begin
            if (cols.size() < MAX_RESULTS) cols.push_back(j * (xq - 1) + k - 1);
         end
      end
      kept_total = kept_total + ROW_END_W'(cols.size());
      walk_prow++;
      if (cols.size() == 0) begin
         res.push_back(make_rsp(0, 1'b0, kept_total, 1'b1, 1'b0));
         return;
      end
      foreach (cols[k]) begin
         res.push_back(make_rsp(cols[k], 1'b1, kept_total, k == cols.size() - 1, 1'b0));
      end
   endfunction

   function automatic void add_mask(int unsigned erow, int unsigned ecol, logic used);
      dir_step_type s;
      s.op    = STEP_ITEM;
      s.kind  = KIND_MASK;
      s.erow  = erow[EROW_W-1:0];
      s.ecol  = ecol[ECOL_W-1:0];
      s.used  = used;
      s.typed = 1'b0;
      s.want  = '0;
      dir_steps.push_back(s);
   endfunction

   function automatic void add_row(bit typed = 1'b0, rsp_type want = '0);
      dir_step_type s;
      s.op    = STEP_ITEM;
      s.kind  = KIND_ROW;
      s.erow  = '0;
      s.ecol  = '0;
      s.used  = 1'b0;
      s.typed = typed;
      s.want  = want;
      dir_steps.push_back(s);
   endfunction

   function automatic void add_csr(csr_idx_type idx, int unsigned val);
      dir_step_type s;
      s.op      = STEP_CSR;
      s.reg_idx = idx;
      s.reg_val = val[CSR_DATA_W-1:0];
      dir_steps.push_back(s);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic send_item(input logic kind, input logic [EROW_W-1:0] erow,
                            input logic [ECOL_W-1:0] ecol, input logic used,
                            input bit typed, input rsp_type want);
      rsp_type row_rsp [$];
      @(negedge clock);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, used, ecol, erow};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_MASK) begin
         store_mask_bit(erow, ecol, used);
      end else begin
         walk_next_row(row_rsp);
         if (typed) row_rsp_q.push_back(want);
         else foreach (row_rsp[k]) row_rsp_q.push_back(row_rsp[k]);
      end
   endtask

   task automatic send_random_mask();
      int unsigned lim_rows;
      int unsigned lim_cols;
      logic [EROW_W-1:0] erow;
      logic [ECOL_W-1:0] ecol;
      lim_rows = clamp_to(cfg_yc, 1, 6);
      lim_cols = clamp_to(cfg_xc, 1, GRID_COLS);
      erow = ($urandom_range(3) == 0) ? EROW_W'($urandom_range(0, GRID_ROWS - 1))
                                      : EROW_W'($urandom_range(0, lim_rows - 1));
      ecol = ($urandom_range(3) == 0) ? ECOL_W'($urandom_range(0, GRID_COLS - 1))
                                      : ECOL_W'($urandom_range(0, lim_cols - 1));
      send_item(KIND_MASK, erow, ecol, $urandom_range(9) < 7, 1'b0, '0);
   endtask

   // wait until every result is in and the block has gone quiet
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (row_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input int unsigned val);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      write_grid_reg(idx, val[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_tready <= !(rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         result_count++;
         if (row_rsp_q.size() == 0) begin
            report_mismatch($sformatf("item %0d with nothing pending, tdata %h",
                                      result_count, rsp_tdata));
         end else begin
            head_rsp = row_rsp_q.pop_front();
            if (rsp_tdata[COL_W-1:0] !== head_rsp.column)
               report_mismatch($sformatf("item %0d column %0d, want %0d", result_count,
                                         rsp_tdata[COL_W-1:0], head_rsp.column));
            if (rsp_tdata[COL_W] !== head_rsp.has_column)
               report_mismatch($sformatf("item %0d has_column %0b, want %0b", result_count,
                                         rsp_tdata[COL_W], head_rsp.has_column));
            if (rsp_tdata[COL_W+1 +: ROW_END_W] !== head_rsp.row_end)
               report_mismatch($sformatf("item %0d row_end %0d, want %0d", result_count,
                                         rsp_tdata[COL_W+1 +: ROW_END_W], head_rsp.row_end));
            if (rsp_tlast !== head_rsp.last)
               report_mismatch($sformatf("item %0d tlast %0b, want %0b", result_count,
                                         rsp_tlast, head_rsp.last));
            if (rsp_tuser !== head_rsp.finished)
               report_mismatch($sformatf("item %0d finished %0b, want %0b", result_count,
                                         rsp_tuser, head_rsp.finished));
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("masked_grid_sparse_row_index regression: fail");
         $finish;
      end
   end

   initial begin
      int               left;
      int               burst;
      int               extra;
      int unsigned      xp_v;
      int unsigned      yp_v;
      int unsigned      xc_v;
      int unsigned      yc_v;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_MASK;
      csr_we     = 1'b0;
      csr_index  = CSR_X_POINTS;
      csr_wdata  = '0;
      foreach (mask_rows[r]) mask_rows[r] = '0;
      cfg_xp = 4'd9;
      cfg_yp = 4'd9;
      cfg_xc = 4'd8;
      cfg_yc = 7'd64;
      restart_walk();

      // empty grid, neighbor patterns, clamping, end of walk, narrowest elements
      add_row(1'b1, make_rsp(0, 1'b0, 0, 1'b1, 1'b0));
      add_mask(0, 0, 1'b1);
      add_mask(0, 1, 1'b1);
      add_mask(0, 3, 1'b1);
      add_mask(1, 0, 1'b1);
      add_mask(1, 1, 1'b1);
      add_mask(1, 2, 1'b1);
      add_mask(1, 3, 1'b1);
      add_mask(1, 4, 1'b0);
      add_mask(63, 7, 1'b1);
      add_row();
      add_row();
      add_csr(CSR_Y_POINTS, 3);
      repeat (4) add_row();
      add_csr(CSR_X_POINTS, 15);
      add_csr(CSR_Y_COUNT, 127);
      add_csr(CSR_X_COUNT, 0);
      add_row();
      add_csr(CSR_Y_POINTS, 0);
      add_csr(CSR_Y_COUNT, 1);
      add_row(1'b1, make_rsp(0, 1'b0, 0, 1'b1, 1'b1));
      add_row(1'b1, make_rsp(0, 1'b0, 0, 1'b1, 1'b1));
      add_csr(CSR_X_POINTS, 2);
      add_csr(CSR_Y_POINTS, 4);
      add_csr(CSR_Y_COUNT, 2);
      add_csr(CSR_X_COUNT, 15);
      repeat (6) add_row();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_steps[i]) begin
         if (dir_steps[i].op == STEP_CSR)
            write_csr(dir_steps[i].reg_idx, dir_steps[i].reg_val);
         else
            send_item(dir_steps[i].kind, dir_steps[i].erow, dir_steps[i].ecol,
                      dir_steps[i].used, dir_steps[i].typed, dir_steps[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p % 4)
            0: begin src_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin src_idle_pct = 53; rsp_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  rsp_stall_pct = 53; end
            default: begin src_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         if (p == 0) begin
            xp_v = 9; yp_v = 9; xc_v = 8; yc_v = 64;
         end else if (p == 1) begin
            xp_v = 2; yp_v = 2; xc_v = 1; yc_v = 1;
         end else begin
            xp_v = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 9);
            yp_v = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 9);
            xc_v = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            yc_v = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 4);
         end
         write_csr(CSR_X_POINTS, xp_v);
         write_csr(CSR_Y_POINTS, yp_v);
         write_csr(CSR_X_COUNT, xc_v);
         write_csr(CSR_Y_COUNT, yc_v);

         left = PHASE_ITEMS;
         while (left > 0) begin
            burst = $urandom_range(2, 12);
            while (burst > 0 && left > 0) begin
               send_random_mask();
               burst--;
               left--;
            end
            extra = $urandom_range(0, 2);
            while (left > 0) begin
               if ($urandom_range(99) < 5)
                  send_random_mask();
               else
                  send_item(KIND_ROW, EROW_W'($urandom_range(0, GRID_ROWS - 1)),
                            ECOL_W'($urandom_range(0, GRID_COLS - 1)),
                            1'($urandom_range(1)), 1'b0, '0);
               left--;
               if (walk_done) begin
                  if (extra == 0) break;
                  extra--;
               end
            end
         end
      end

      drain();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && row_rsp_q.size() == 0)
         $display("masked_grid_sparse_row_index regression: pass");
      else
         $display("masked_grid_sparse_row_index regression: fail");
      $finish;
   end

endmodule
